>>> src/mrd_pkg.sv
// Shared types and codes for the moving RMS decimator.
`default_nettype none
package mrd_pkg;

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_QUERY  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [1:0] REG_CHANNELS = 2'd0;
	localparam logic [1:0] REG_HISTORY  = 2'd1;
	localparam logic [1:0] REG_WINDOW   = 2'd2;
	localparam logic [1:0] REG_DECIM    = 2'd3;

	localparam logic ITER_DIV  = 1'b0;
	localparam logic ITER_SQRT = 1'b1;

	localparam int OPND_W = 56;
	localparam int VAL_W  = 24;

	typedef struct packed {
		logic start;
		logic mode;
	} iter_req_t;

endpackage
`default_nettype wire

>>> src/mrd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mrd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> src/mrd_iter.sv
// Shared shift/compare/subtract unit: restoring divide or integer square root.
`default_nettype none
module mrd_iter (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mrd_pkg::iter_req_t  req,
	input  wire logic [55:0]         opnd,
	input  wire logic [8:0]          dvsr,
	output logic                     done,
	output logic [55:0]              res
);
	import mrd_pkg::*;

	logic        busy_q;
	logic        mode_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [55:0] acc_q;
	logic [31:0] rem_q;
	logic [27:0] root_q;
	logic [8:0]  dv_q;
	logic [31:0] r;
	logic [31:0] sub;
	logic [31:0] diff;
	logic        ge;
	logic [5:0]  last;

	always_comb begin
		if (mode_q == ITER_DIV) begin
			r    = {rem_q[30:0], acc_q[55]};
			sub  = {23'b0, dv_q};
			last = 6'd55;
		end else begin
			r    = {rem_q[29:0], acc_q[55:54]};
			sub  = {2'b0, root_q, 2'b01};
			last = 6'd27;
		end
		ge   = r >= sub;
		diff = r - sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mode_q <= ITER_DIV;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				mode_q <= req.mode;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q  <= opnd;
			rem_q  <= '0;
			root_q <= '0;
			dv_q   <= dvsr;
		end else if (busy_q) begin
			rem_q <= ge ? diff : r;
			if (mode_q == ITER_DIV) begin
				acc_q <= {acc_q[54:0], ge};
			end else begin
				acc_q  <= {acc_q[53:0], 2'b00};
				root_q <= {root_q[26:0], ge};
			end
		end
	end

	assign done = done_q;
	assign res  = (mode_q == ITER_DIV) ? acc_q : {28'b0, root_q};
endmodule
`default_nettype wire

>>> src/multichannel_moving_rms_decimator.sv
// Multichannel moving RMS with history ring and decimated feature readout.
// s_tuser carries the command: add sample, feature query, clear counters.
// s_tdata carries channel, sample and block index. One result word per
// command word on m_tdata: RMS, feature mean, bad-query flag, history-full.
// Registers (channels, history length, window length, decimation) sit on
// the APB port. The user must write them only while the block is idle;
// the block itself does not enforce this. Timing: one word at a time;
// s_tready is low while a word is worked on. A sample takes a window RAM
// read, two squares on the shared multiplier, then 56 divide steps and 28
// root steps on the shared unit. A query in range takes one history
// RAM read per entry, then the 56-step divide; other words go to the output.
// After reset both RAMs are swept to zero, one entry a cycle, over all
// 2**(clog2(MAX_CHANNELS)+clog2(depth)) entries (1024 by default); writing the
// window length sweeps the window RAM again. s_tready is low during a sweep.
// A finished result waits in the output register while the next word is
// worked on; a stalled receiver holds the block only at its next result.
`default_nettype none
module multichannel_moving_rms_decimator #(
	parameter int MAX_CHANNELS  = 4,
	parameter int HISTORY_DEPTH = 256,
	parameter int WINDOW_DEPTH  = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // channel[1:0], sample[17:2], block_index[25:18]
	input  wire logic [1:0]  s_tuser,   // cmd[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // rms_value[23:0], feature_value[47:24],
	                                    // query_bad[48], ready_res[49]
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import mrd_pkg::*;

	localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int WPW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int HPW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int WAW = CHW + WPW;
	localparam int HAW = CHW + HPW;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_SQO  = 4'd2;
	localparam logic [3:0] S_SQN  = 4'd3;
	localparam logic [3:0] S_ADD  = 4'd4;
	localparam logic [3:0] S_DIV  = 4'd5;
	localparam logic [3:0] S_SQRT = 4'd6;
	localparam logic [3:0] S_HWR  = 4'd7;
	localparam logic [3:0] S_QMUL = 4'd8;
	localparam logic [3:0] S_QCHK = 4'd9;
	localparam logic [3:0] S_QRD  = 4'd10;
	localparam logic [3:0] S_QACC = 4'd11;
	localparam logic [3:0] S_QDIV = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;

	// configuration
	logic [2:0] ach_q;
	logic [8:0] hlen_q;
	logic [8:0] wlen_q;
	logic [8:0] dec_q;
	logic [4:0] eff_ch;
	logic [8:0] eff_hist;
	logic [8:0] eff_win;
	logic [8:0] eff_dec;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[3:2])
			REG_CHANNELS: prdata = {29'b0, ach_q};
			REG_HISTORY:  prdata = {23'b0, hlen_q};
			REG_WINDOW:   prdata = {23'b0, wlen_q};
			REG_DECIM:    prdata = {23'b0, dec_q};
			default:      prdata = '0;
		endcase
	end

	always_comb begin
		if (ach_q == 3'd0) begin
			eff_ch = 5'd1;
		end else if (32'(ach_q) > MAX_CHANNELS) begin
			eff_ch = 5'(MAX_CHANNELS);
		end else begin
			eff_ch = {2'b0, ach_q};
		end
		if (hlen_q == 9'd0) begin
			eff_hist = 9'd1;
		end else if (32'(hlen_q) > HISTORY_DEPTH) begin
			eff_hist = 9'(HISTORY_DEPTH);
		end else begin
			eff_hist = hlen_q;
		end
		if (wlen_q == 9'd0) begin
			eff_win = 9'd1;
		end else if (32'(wlen_q) > WINDOW_DEPTH) begin
			eff_win = 9'(WINDOW_DEPTH);
		end else begin
			eff_win = wlen_q;
		end
		if (dec_q == 9'd0) begin
			eff_dec = 9'd1;
		end else if (dec_q > 9'd256) begin
			eff_dec = 9'd256;
		end else begin
			eff_dec = dec_q;
		end
	end

	// state
	logic [3:0]     state_q;
	logic [1:0]     cmd_q;
	logic [1:0]     ch_q;
	logic [15:0]    smp_q;
	logic [7:0]     blk_q;
	logic [CHW-1:0] chi;
	logic [WPW-1:0] wpos_q [MAX_CHANNELS];
	logic [39:0]    ssum_q [MAX_CHANNELS];
	logic [HPW-1:0] hwp_q;
	logic [8:0]     fill_q;
	logic [31:0]    sq_q;
	logic [39:0]    sum40_q;
	logic [31:0]    qsum_q;
	logic [HPW-1:0] idx_q;
	logic [8:0]     k_q;
	logic           rd_v_s1;
	logic [23:0]    rms_q;
	logic [23:0]    feat_q;
	logic           bad_q;
	logic           mvalid_q;
	logic [55:0]    mdata_q;
	logic           wclr_q;
	logic           hclr_q;
	logic [WAW-1:0] wcnt_q;
	logic [HAW-1:0] hcnt_q;

	// shared multiplier
	logic [15:0] mul_a;
	logic [15:0] mul_b;
	logic [31:0] mul_p;

	// RAM ports
	logic           win_we;
	logic [WAW-1:0] win_waddr;
	logic [15:0]    win_wdata;
	logic [WAW-1:0] win_raddr;
	logic [15:0]    win_rdata;
	logic           hist_we;
	logic [HAW-1:0] hist_waddr;
	logic [23:0]    hist_wdata;
	logic [HAW-1:0] hist_raddr;
	logic [23:0]    hist_rdata;

	// shared divide / root unit
	iter_req_t   ireq;
	logic [55:0] iopnd;
	logic [8:0]  idvsr;
	logic        idone;
	logic [55:0] ires;

	logic        accept;
	logic        smp_ok;
	logic        out_free;
	logic [39:0] new_sum;
	logic [31:0] qbase;
	logic [31:0] qlim;

	assign chi      = CHW'(ch_q);
	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE) && !wclr_q && !hclr_q;
	assign smp_ok   = {3'b0, s_tdata[1:0]} < eff_ch;
	assign out_free = !mvalid_q || m_tready;
	assign new_sum  = sum40_q + {8'b0, sq_q};
	assign qlim     = {23'b0, eff_hist};
	assign qbase    = 32'(hwp_q) + sq_q - 32'(eff_dec);

	always_comb begin
		unique case (state_q)
			S_SQO: begin
				mul_a = win_rdata;
				mul_b = win_rdata;
			end
			S_QMUL: begin
				mul_a = {7'b0, 9'(blk_q) + 9'd1};
				mul_b = {7'b0, eff_dec};
			end
			default: begin
				mul_a = smp_q;
				mul_b = smp_q;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		ireq.start = 1'b0;
		ireq.mode  = ITER_DIV;
		iopnd      = {ires[39:0], 16'b0};
		idvsr      = eff_win;
		priority case (1'b1)
			state_q == S_ADD: begin
				ireq.start = 1'b1;
				iopnd      = {new_sum, 16'b0};
			end
			state_q == S_DIV && idone: begin
				ireq.start = 1'b1;
				ireq.mode  = ITER_SQRT;
				iopnd      = ires;
			end
			state_q == S_QACC: begin
				ireq.start = 1'b1;
				iopnd      = {24'b0, qsum_q + {8'b0, hist_rdata}};
				idvsr      = eff_dec;
			end
			default: begin
				ireq.start = 1'b0;
			end
		endcase
	end

	always_comb begin
		win_raddr = {chi, wpos_q[chi]};
		if (wclr_q) begin
			win_we    = 1'b1;
			win_waddr = wcnt_q;
			win_wdata = '0;
		end else begin
			win_we    = state_q == S_ADD;
			win_waddr = {chi, wpos_q[chi]};
			win_wdata = smp_q;
		end
		hist_raddr = {chi, idx_q};
		if (hclr_q) begin
			hist_we    = 1'b1;
			hist_waddr = hcnt_q;
			hist_wdata = '0;
		end else begin
			hist_we    = state_q == S_HWR;
			hist_waddr = {chi, hwp_q};
			hist_wdata = rms_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ach_q    <= 3'd4;
			hlen_q   <= 9'd256;
			wlen_q   <= 9'd64;
			dec_q    <= 9'd8;
			state_q  <= S_IDLE;
			hwp_q    <= '0;
			fill_q   <= '0;
			mvalid_q <= 1'b0;
			wclr_q   <= 1'b1;
			hclr_q   <= 1'b1;
			wcnt_q   <= '0;
			hcnt_q   <= '0;
			rd_v_s1  <= 1'b0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				wpos_q[i] <= '0;
				ssum_q[i] <= '0;
			end
		end else begin
			rd_v_s1 <= state_q == S_QRD;
			if (state_q == S_DONE && out_free) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
			if (wclr_q) begin
				wcnt_q <= wcnt_q + 1'b1;
				if (&wcnt_q) begin
					wclr_q <= 1'b0;
				end
			end
			if (hclr_q) begin
				hcnt_q <= hcnt_q + 1'b1;
				if (&hcnt_q) begin
					hclr_q <= 1'b0;
				end
			end
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_CHANNELS: ach_q <= pwdata[2:0];
					REG_HISTORY: begin
						hlen_q <= pwdata[8:0];
						hwp_q  <= '0;
						fill_q <= '0;
					end
					REG_WINDOW: begin
						wlen_q <= pwdata[8:0];
						wclr_q <= 1'b1;
						wcnt_q <= '0;
						for (int i = 0; i < MAX_CHANNELS; i++) begin
							wpos_q[i] <= '0;
							ssum_q[i] <= '0;
						end
					end
					REG_DECIM: dec_q <= pwdata[8:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (s_tuser == CMD_SAMPLE && smp_ok) begin
							state_q <= S_RD;
						end else if (s_tuser == CMD_QUERY) begin
							state_q <= S_QMUL;
						end else begin
							if (s_tuser == CMD_CLEAR) begin
								hwp_q  <= '0;
								fill_q <= '0;
							end
							state_q <= S_DONE;
						end
					end
				end
				S_RD:   state_q <= S_SQO;
				S_SQO:  state_q <= S_SQN;
				S_SQN:  state_q <= S_ADD;
				S_ADD: begin
					ssum_q[chi] <= new_sum;
					if (32'(wpos_q[chi]) + 1 >= 32'(eff_win)) begin
						wpos_q[chi] <= '0;
					end else begin
						wpos_q[chi] <= wpos_q[chi] + 1'b1;
					end
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (idone) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (idone) begin
						state_q <= S_HWR;
					end
				end
				S_HWR: begin
					if ({3'b0, ch_q} + 5'd1 == eff_ch) begin
						if (32'(hwp_q) + 1 >= 32'(eff_hist)) begin
							hwp_q <= '0;
						end else begin
							hwp_q <= hwp_q + 1'b1;
						end
						if (fill_q < eff_hist) begin
							fill_q <= fill_q + 9'd1;
						end
					end
					state_q <= S_DONE;
				end
				S_QMUL: state_q <= S_QCHK;
				S_QCHK: begin
					if (32'(ch_q) >= MAX_CHANNELS || sq_q > qlim) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_QRD;
					end
				end
				S_QRD: begin
					if (k_q + 9'd1 == eff_dec) begin
						state_q <= S_QACC;
					end
				end
				S_QACC: state_q <= S_QDIV;
				S_QDIV: begin
					if (idone) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= s_tuser;
			ch_q   <= s_tdata[1:0];
			smp_q  <= s_tdata[17:2];
			blk_q  <= s_tdata[25:18];
			rms_q  <= '0;
			feat_q <= '0;
			bad_q  <= 1'b0;
		end
		if (state_q == S_SQO || state_q == S_SQN || state_q == S_QMUL) begin
			sq_q <= mul_p;
		end
		if (state_q == S_SQN) begin
			sum40_q <= ssum_q[chi] - {8'b0, sq_q};
		end
		if (state_q == S_SQRT && idone) begin
			rms_q <= ires[23:0];
		end
		if (state_q == S_QCHK) begin
			if (32'(ch_q) >= MAX_CHANNELS || sq_q > qlim) begin
				bad_q <= cmd_q == CMD_QUERY;
			end
			idx_q  <= (qbase >= qlim) ? HPW'(qbase - qlim) : HPW'(qbase);
			k_q    <= '0;
			qsum_q <= '0;
		end
		if (state_q == S_QRD) begin
			k_q <= k_q + 9'd1;
			if (32'(idx_q) + 1 >= 32'(eff_hist)) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
			if (rd_v_s1) begin
				qsum_q <= qsum_q + {8'b0, hist_rdata};
			end
		end
		if (state_q == S_QDIV && idone) begin
			feat_q <= ires[23:0];
		end
		if (state_q == S_DONE && out_free) begin
			mdata_q <= {6'b0, fill_q == eff_hist, bad_q, feat_q, rms_q};
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;

	mrd_ram #(
		.WIDTH(16),
		.DEPTH(1 << WAW)
	) u_win_ram (
		.clk  (clk),
		.we   (win_we),
		.waddr(win_waddr),
		.wdata(win_wdata),
		.raddr(win_raddr),
		.rdata(win_rdata)
	);

	mrd_ram #(
		.WIDTH(VAL_W),
		.DEPTH(1 << HAW)
	) u_hist_ram (
		.clk  (clk),
		.we   (hist_we),
		.waddr(hist_waddr),
		.wdata(hist_wdata),
		.raddr(hist_raddr),
		.rdata(hist_rdata)
	);

	mrd_iter u_iter (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (ireq),
		.opnd  (iopnd),
		.dvsr  (idvsr),
		.done  (idone),
		.res   (ires)
	);
endmodule
`default_nettype wire

>>> bench/multichannel_moving_rms_decimator_tb.sv
// Self-checking bench for the moving RMS decimator: stream words, APB setup, scoreboard.
`default_nettype none
module multichannel_moving_rms_decimator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mrd_pkg::*;

	typedef struct packed {
		logic [23:0] rms;
		logic [23:0] feat;
		logic        bad;
		logic        full;
	} rms_res_t;

	class rms_scoreboard;
		int unsigned chans, hist_len, win_len, decim;
		logic [15:0] win_ram [4][256];
		int unsigned win_pos [4];
		longint unsigned sq_sum [4];
		logic [23:0] hist_ram [4][256];
		int unsigned wr_pos, fill;
		rms_res_t pending[$];
		int errors;

		function new();
			chans = 4; hist_len = 256; win_len = 64; decim = 8;
			clear_windows();
			foreach (hist_ram[c, i]) hist_ram[c][i] = '0;
			wr_pos = 0; fill = 0; errors = 0;
		endfunction

		function void clear_windows();
			foreach (win_ram[c, i]) win_ram[c][i] = '0;
			foreach (win_pos[c]) begin
				win_pos[c] = 0;
				sq_sum[c] = 0;
			end
		endfunction

		function int unsigned clamp(int unsigned v, int unsigned hi);
			if (v < 1) return 1;
			if (v > hi) return hi;
			return v;
		endfunction

		function longint unsigned isqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			int unsigned v;
			v = val[8:0];
			case (idx)
				REG_CHANNELS: chans = v & 7;
				REG_HISTORY: begin
					hist_len = v; wr_pos = 0; fill = 0;
				end
				REG_WINDOW: begin
					win_len = v; clear_windows();
				end
				REG_DECIM: decim = v;
			endcase
		endfunction

		function void note_word(logic [1:0] cmd, logic [1:0] ch, logic [15:0] smp,
				logic [7:0] blk);
			rms_res_t r;
			int unsigned h, w, c, p, d, st;
			longint unsigned old, s;
			r = '0;
			h = clamp(hist_len, 256);
			c = clamp(chans, 4);
			if (cmd == CMD_SAMPLE) begin
				if (ch < c) begin
					w = clamp(win_len, 256);
					p = win_pos[ch];
					if (p >= w) p = 0;
					old = win_ram[ch][p];
					sq_sum[ch] = sq_sum[ch] - old * old + longint'(smp) * smp;
					win_ram[ch][p] = smp;
					p++;
					if (p >= w) p = 0;
					win_pos[ch] = p;
					r.rms = 24'(isqrt((sq_sum[ch] << 16) / w));
					if (wr_pos >= h) wr_pos = 0;
					hist_ram[ch][wr_pos] = r.rms;
					if (ch + 1 == c) begin
						wr_pos = (wr_pos + 1) % h;
						if (fill < h) fill++;
					end
				end
			end else if (cmd == CMD_QUERY) begin
				d = clamp(decim, 256);
				if (blk >= h / d) begin
					r.bad = 1'b1;
				end else begin
					s = 0;
					st = wr_pos % h;
					for (int k = 0; k < d; k++) s += hist_ram[ch][(st + blk * d + k) % h];
					r.feat = 24'(s / d);
				end
			end else if (cmd == CMD_CLEAR) begin
				wr_pos = 0; fill = 0;
			end
			r.full = (fill == h);
			pending.push_back(r);
		endfunction

		function void check_word(logic [55:0] data);
			rms_res_t e;
			if (pending.size() == 0) begin
				report("unexpected result word", 0, data[23:0]);
				return;
			end
			e = pending.pop_front();
			if (data[23:0] !== e.rms) report("rms_value", e.rms, data[23:0]);
			if (data[47:24] !== e.feat) report("feature_value", e.feat, data[47:24]);
			if (data[48] !== e.bad) report("query_bad", e.bad, data[48]);
			if (data[49] !== e.full) report("ready_res", e.full, data[49]);
		endfunction

		function void report(string what, longint unsigned exp_v, longint unsigned got);
			errors++;
			if (errors <= 30) $display("mismatch %s: expected %0h got %0h", what, exp_v, got);
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
	logic [31:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic [55:0] m_tdata;
	logic psel = 0, penable = 0, pwrite = 0, pready;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;

	rms_scoreboard sb;
	int src_idle = 10, snk_idle = 51;
	int hold_off = 0;
	int unsigned qmax = 0;

	always #2 clk = ~clk;

	multichannel_moving_rms_decimator dut (.*);

	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle);
		end
		if (m_tvalid && m_tready) sb.check_word(m_tdata);
	end

	task automatic apb_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.write_reg(idx, val);
	endtask

	task automatic send_word(logic [1:0] cmd, logic [1:0] ch, logic [15:0] smp,
			logic [7:0] blk);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= {6'd0, blk, smp, ch};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_word(cmd, ch, smp, blk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	// mostly full frames of samples, some queries in range
	task automatic random_words(int n);
		int unsigned c, hl, d;
		logic [1:0] cmd;
		for (int i = 0; i < n; i++) begin
			c = sb.clamp(sb.chans, 4);
			hl = sb.clamp(sb.hist_len, 256);
			d = sb.clamp(sb.decim, 256);
			case ($urandom_range(19))
				0, 1, 2: send_word(CMD_QUERY, 2'($urandom),
					16'($urandom), (hl / d > 0 && $urandom_range(3) != 0) ?
					8'($urandom_range(hl / d - 1)) : 8'($urandom));
				3: begin
					cmd = 2'($urandom);
					send_word(cmd == CMD_SAMPLE ? CMD_CLEAR : cmd, 2'($urandom),
						16'($urandom), 8'($urandom));
				end
				4: send_word(CMD_SAMPLE, 2'($urandom), 16'($urandom), 8'($urandom));
				default: for (int k = 0; k < c; k++)
					send_word(CMD_SAMPLE, 2'(k), ($urandom_range(3) == 0) ? 16'hffff :
						16'($urandom), 8'($urandom));
			endcase
		end
	endtask

	task automatic phase(int chans_v, int hist_v, int win_v, int dec_v, int n);
		drain();
		apb_write(REG_CHANNELS, chans_v);
		apb_write(REG_HISTORY, hist_v);
		apb_write(REG_WINDOW, win_v);
		apb_write(REG_DECIM, dec_v);
		random_words(n);
	endtask

	initial begin
		#200000000;
		$display("** multichannel_moving_rms_decimator: FAILED **");
		$finish;
	end

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		// directed
		send_word(CMD_QUERY, 0, 0, 0);
		send_word(CMD_QUERY, 3, 0, 8'hff);
		for (int k = 0; k < 4; k++) send_word(CMD_SAMPLE, 2'(k), 16'hffff, 0);
		for (int k = 0; k < 4; k++) send_word(CMD_SAMPLE, 2'(k), 16'h0000, 8'hff);
		send_word(CMD_QUERY, 2, 16'hffff, 31);
		send_word(CMD_QUERY, 1, 0, 32);
		send_word(2'd3, 3, 16'hffff, 8'hff);
		send_word(CMD_CLEAR, 0, 0, 0);
		drain();
		apb_write(REG_CHANNELS, 0);
		apb_write(REG_HISTORY, 0);
		apb_write(REG_WINDOW, 0);
		apb_write(REG_DECIM, 0);
		send_word(CMD_SAMPLE, 0, 16'hffff, 0);
		send_word(CMD_SAMPLE, 1, 16'h1234, 0);
		send_word(CMD_QUERY, 0, 0, 0);
		send_word(CMD_QUERY, 3, 0, 1);
		drain();
		apb_write(REG_CHANNELS, 7);
		apb_write(REG_HISTORY, 9'h1ff);
		apb_write(REG_WINDOW, 9'h1ff);
		apb_write(REG_DECIM, 9'h1ff);
		send_word(CMD_SAMPLE, 3, 16'hffff, 0);
		send_word(CMD_QUERY, 3, 0, 0);
		// random
		phase(2, 8, 4, 2, 75);
		phase(4, 16, 3, 5, 75);
		phase(1, 4, 1, 1, 75);
		phase(3, 7, 256, 8, 75);
		// long receiver stall while sender keeps offering
		hold_off = 300;
		random_words(20);
		drain();
		src_idle = 51; snk_idle = 10;
		phase(4, 12, 2, 20, 75);
		phase(2, 1, 5, 1, 75);
		phase(4, 256, 8, 256, 30);
		src_idle = 0; snk_idle = 0;
		phase(3, 10, 7, 3, 75);
		phase(4, 6, 2, 2, 75);
		phase(4, 256, 64, 8, 30);
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("** multichannel_moving_rms_decimator: PASSED **");
		end else begin
			$display("** multichannel_moving_rms_decimator: FAILED **");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> multichannel_moving_rms_decimator.f
src/mrd_pkg.sv
src/mrd_ram.sv
src/mrd_iter.sv
src/multichannel_moving_rms_decimator.sv
bench/multichannel_moving_rms_decimator_tb.sv
